// ----- rtl/bdpc_pkg.sv -----
// ----------------------------------------------------------------------------
// bdpc_pkg
// Shared types and constants for the button debounce / press classifier.
// ----------------------------------------------------------------------------
package bdpc_pkg;

    localparam int unsigned CFG_W    = 16;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned PADDR_W  = 4;
    localparam int unsigned PDATA_W  = 32;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST  = 16'd50;
    localparam logic [CFG_W-1:0] LONG_RST      = 16'd3000;
    localparam logic [CFG_W-1:0] SHORT_MAX_RST = 16'd2000;

    typedef enum logic [1:0] {
        REG_DEBOUNCE  = 2'd0,
        REG_LONG      = 2'd1,
        REG_SHORT_MAX = 2'd2,
        REG_NONE      = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_SHORT = 2'd1,
        EV_LONG  = 2'd2,
        EV_RSVD  = 2'd3
    } t_event;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] long_press_ms;
        logic [CFG_W-1:0] short_press_max_ms;
    } t_cfg;

endpackage

// ----- rtl/bdpc_core.sv -----
// ----------------------------------------------------------------------------
// bdpc_core
// Debounce state and press classification; one poll per accepted word.
// ----------------------------------------------------------------------------
module bdpc_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_step,
    input  logic [bdpc_pkg::TIME_W-1:0]  i_now_ms,
    input  logic                         i_pin_level,
    input  bdpc_pkg::t_cfg               i_cfg,
    output bdpc_pkg::t_event             o_event
);
    import bdpc_pkg::*;

    logic              r_raw_prev;
    logic              r_stable_pressed;
    logic [TIME_W-1:0] r_change_time;
    logic [TIME_W-1:0] r_press_start;
    logic              r_long_reported;

    logic              n_raw_prev;
    logic              n_stable_pressed;
    logic [TIME_W-1:0] n_change_time;
    logic [TIME_W-1:0] n_press_start;
    logic              n_long_reported;

    logic              pressed;
    logic [TIME_W-1:0] since_change;
    logic [TIME_W-1:0] held;
    t_event            ev;

    assign pressed      = ~i_pin_level;
    assign since_change = i_now_ms - r_change_time;
    assign held         = i_now_ms - r_press_start;

    always_comb begin
        n_raw_prev       = r_raw_prev;
        n_stable_pressed = r_stable_pressed;
        n_change_time    = r_change_time;
        n_press_start    = r_press_start;
        n_long_reported  = r_long_reported;
        ev               = EV_NONE;
        if (i_step) begin
            priority if (pressed != r_raw_prev) begin
                n_raw_prev    = pressed;
                n_change_time = i_now_ms;
            end else if (since_change < {{(TIME_W-CFG_W){1'b0}}, i_cfg.debounce_ms}) begin
                ev = EV_NONE;
            end else if (pressed == r_stable_pressed) begin
                if (r_stable_pressed && !r_long_reported &&
                    held >= {{(TIME_W-CFG_W){1'b0}}, i_cfg.long_press_ms}) begin
                    n_long_reported = 1'b1;
                    ev              = EV_LONG;
                end
            end else begin
                n_stable_pressed = pressed;
                if (pressed) begin
                    n_press_start   = i_now_ms;
                    n_long_reported = 1'b0;
                end else if (!r_long_reported &&
                             held < {{(TIME_W-CFG_W){1'b0}}, i_cfg.short_press_max_ms}) begin
                    ev = EV_SHORT;
                end
            end
        end
    end

    assign o_event = ev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_prev       <= 1'b0;
            r_stable_pressed <= 1'b0;
            r_change_time    <= '0;
            r_press_start    <= '0;
            r_long_reported  <= 1'b0;
        end else begin
            r_raw_prev       <= n_raw_prev;
            r_stable_pressed <= n_stable_pressed;
            r_change_time    <= n_change_time;
            r_press_start    <= n_press_start;
            r_long_reported  <= n_long_reported;
        end
    end

`ifndef ASSERT_OFF
    a_long_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ev == EV_LONG) |=> r_long_reported)
        else $error("long press not recorded");

    a_short_on_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ev == EV_SHORT) |-> (r_stable_pressed && !r_long_reported && !pressed))
        else $error("short press outside a release");

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> ($stable(r_stable_pressed) && $stable(r_change_time) &&
                     $stable(r_long_reported)))
        else $error("state moved without a poll");

    a_no_event_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |-> (ev == EV_NONE))
        else $error("event without a poll");
`endif

endmodule

// ----- rtl/button_debounce_press_classifier.sv -----
// ----------------------------------------------------------------------------
// button_debounce_press_classifier
// Debounces a sampled pull-up button and reports short and long presses.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall carry one poll word (i_now_ms, i_pin_level;
// pin low = pressed). Output channel: o_valid / i_stall carry one word
// o_press_event (0 none, 1 short, 2 long) for every poll, in order.
// The result is registered and appears in the cycle after the poll is taken.
// Throughput: one poll per cycle while o_stall is low; the debounce state
// update is a 32-bit subtract and compare on a few registers, done in the
// cycle of the poll. The single output register lets a new poll enter while
// the previous result is being taken; if the receiver stalls with a result
// held, o_stall rises and the poll waits until that result leaves.
// Config: APB registers at 0x0 debounce_ms, 0x4 long_press_ms,
// 0x8 short_press_max_ms (16 bits each); write only while idle.
// Reset (synchronous, i_rst_n low): no result pending, debounce state
// cleared, registers at 50 / 3000 / 2000 ms.
// ----------------------------------------------------------------------------
module button_debounce_press_classifier (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [bdpc_pkg::TIME_W-1:0]    i_now_ms,
    input  logic                           i_pin_level,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [1:0]                     o_press_event,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bdpc_pkg::PADDR_W-1:0]   paddr,
    input  logic [bdpc_pkg::PDATA_W-1:0]   pwdata,
    output logic [bdpc_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);
    import bdpc_pkg::*;

    t_cfg     r_cfg;
    logic     r_out_valid;
    t_event   r_event;
    t_event   core_event;
    logic     step;
    logic     cfg_wr;
    t_reg_idx reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms        <= DEBOUNCE_RST;
            r_cfg.long_press_ms      <= LONG_RST;
            r_cfg.short_press_max_ms <= SHORT_MAX_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_DEBOUNCE:  r_cfg.debounce_ms        <= pwdata[CFG_W-1:0];
                REG_LONG:      r_cfg.long_press_ms      <= pwdata[CFG_W-1:0];
                REG_SHORT_MAX: r_cfg.short_press_max_ms <= pwdata[CFG_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_DEBOUNCE:  prdata = {{(PDATA_W-CFG_W){1'b0}}, r_cfg.debounce_ms};
            REG_LONG:      prdata = {{(PDATA_W-CFG_W){1'b0}}, r_cfg.long_press_ms};
            REG_SHORT_MAX: prdata = {{(PDATA_W-CFG_W){1'b0}}, r_cfg.short_press_max_ms};
            default:       prdata = '0;
        endcase
    end

    assign o_stall = r_out_valid && i_stall;
    assign step    = i_valid && !o_stall;

    bdpc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_now_ms    (i_now_ms),
        .i_pin_level (i_pin_level),
        .i_cfg       (r_cfg),
        .o_event     (core_event)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!o_stall) begin
            r_out_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_event <= core_event;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_press_event = r_event;

endmodule

// ----- verif/button_debounce_press_classifier_tb.sv -----
// ----------------------------------------------------------------------------
// button_debounce_press_classifier_tb
// Self-checking testbench: register access over APB, directed poll sequences
// covering bounce, short, long and zero-limit presses, then random press
// sequences across several register settings and idle patterns. Every result
// word is compared with a cycle-free model of the debounce and press logic.
// ----------------------------------------------------------------------------
module button_debounce_press_classifier_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bdpc_pkg::*;

    localparam int unsigned CYCLE_LIMIT     = 400000;
    localparam int unsigned ITEMS_PER_PHASE = 55;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_valid     = 1'b0;
    logic                o_stall;
    logic [TIME_W-1:0]   i_now_ms    = '0;
    logic                i_pin_level = 1'b1;
    logic                o_valid;
    logic                i_stall     = 1'b0;
    logic [1:0]          o_press_event;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [PADDR_W-1:0]  paddr       = '0;
    logic [PDATA_W-1:0]  pwdata      = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    button_debounce_press_classifier dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_now_ms      (i_now_ms),
        .i_pin_level   (i_pin_level),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_press_event (o_press_event),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    // press classifier model state
    t_cfg          cfg_model = '{DEBOUNCE_RST, LONG_RST, SHORT_MAX_RST};
    logic          raw_pressed_m    = 1'b0;
    logic          stable_pressed_m = 1'b0;
    logic [31:0]   level_change_ms  = '0;
    logic [31:0]   press_start_ms   = '0;
    logic          long_flagged     = 1'b0;

    t_event        expected_events[$];
    logic [31:0]   poll_clock = '0;
    int unsigned   send_idle_pct = 0;
    int unsigned   recv_idle_pct = 0;
    int unsigned   n_polls   = 0;
    int unsigned   n_reg_ops = 0;
    int unsigned   n_fail    = 0;
    int unsigned   short_seen = 0;
    int unsigned   long_seen  = 0;
    int unsigned   cycle_count = 0;

    function automatic t_event predict_event(logic [31:0] now, logic pin);
        logic        pressed;
        logic [31:0] since_change;
        logic [31:0] held;
        pressed = ~pin;
        if (pressed != raw_pressed_m) begin
            raw_pressed_m   = pressed;
            level_change_ms = now;
            return EV_NONE;
        end
        since_change = now - level_change_ms;
        if (since_change < {16'h0, cfg_model.debounce_ms})
            return EV_NONE;
        held = now - press_start_ms;
        if (pressed == stable_pressed_m) begin
            if (stable_pressed_m && !long_flagged && held >= {16'h0, cfg_model.long_press_ms}) begin
                long_flagged = 1'b1;
                return EV_LONG;
            end
            return EV_NONE;
        end
        stable_pressed_m = pressed;
        if (pressed) begin
            press_start_ms = now;
            long_flagged   = 1'b0;
            return EV_NONE;
        end
        if (long_flagged)
            return EV_NONE;
        if (held < {16'h0, cfg_model.short_press_max_ms})
            return EV_SHORT;
        return EV_NONE;
    endfunction

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_event want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_events.size() == 0) begin
                $error("press_event: unexpected word, got %0d", o_press_event);
                n_fail++;
            end else begin
                want = expected_events.pop_front();
                if (o_press_event !== want) begin
                    $error("press_event mismatch: expected %0d, got %0d", want, o_press_event);
                    n_fail++;
                end else if (want == EV_SHORT) begin
                    short_seen++;
                end else if (want == EV_LONG) begin
                    long_seen++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("button_debounce_press_classifier regression: fail");
            $finish;
        end
    end

    task automatic send_poll(logic [31:0] now, logic pin);
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        i_valid     <= 1'b1;
        i_now_ms    <= now;
        i_pin_level <= pin;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_events.push_back(predict_event(now, pin));
        n_polls++;
    endtask

    task automatic poll_after(int unsigned dt, logic pin);
        poll_clock = poll_clock + dt;
        send_poll(poll_clock, pin);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (expected_events.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_register(t_reg_idx idx, logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        unique case (idx)
            REG_DEBOUNCE:  cfg_model.debounce_ms        = value[15:0];
            REG_LONG:      cfg_model.long_press_ms      = value[15:0];
            REG_SHORT_MAX: cfg_model.short_press_max_ms = value[15:0];
            default: ;
        endcase
        n_reg_ops++;
        @(posedge i_clk);
    endtask

    task automatic check_register(t_reg_idx idx, logic [15:0] want);
        logic [31:0] got;
        psel   <= 1'b1;
        pwrite <= 1'b0;
        paddr  <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        n_reg_ops++;
        if (got !== {16'h0, want}) begin
            $error("%s mismatch: expected %0h, got %0h", idx.name(), want, got);
            n_fail++;
        end
        @(posedge i_clk);
    endtask

    // upper bits carry junk: the block must mask them
    task automatic set_config(logic [15:0] deb, logic [15:0] lng, logic [15:0] shrt);
        drain_results();
        write_register(REG_DEBOUNCE,  {16'($urandom()), deb});
        write_register(REG_LONG,      {16'($urandom()), lng});
        write_register(REG_SHORT_MAX, {16'($urandom()), shrt});
        check_register(REG_DEBOUNCE,  deb);
        check_register(REG_LONG,      lng);
        check_register(REG_SHORT_MAX, shrt);
    endtask

    function automatic int near(int x);
        if (x == 0)
            return $urandom_range(0, 1);
        return x - 1 + $urandom_range(0, 2);
    endfunction

    function automatic int pick_hold();
        int s;
        int l;
        s = int'(cfg_model.short_press_max_ms);
        l = int'(cfg_model.long_press_ms);
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, s);
            1: return near(s);
            2: return $urandom_range(s, l);
            3: return near(l);
            4: return l + $urandom_range(0, l / 2 + 5);
            default: return 0;
        endcase
    endfunction

    // bounce, debounced press, hold, bounce, debounced release
    task automatic press_sequence();
        int deb;
        int hold;
        int elapsed;
        int stepv;
        int k;
        int n;
        deb  = int'(cfg_model.debounce_ms);
        hold = pick_hold();
        n = $urandom_range(0, 3);
        for (k = 0; k < n; k++)
            poll_after($urandom_range(0, deb / 2 + 1), k[0]);
        poll_after($urandom_range(0, deb / 2 + 1), 1'b0);
        poll_after(near(deb), 1'b0);
        poll_after($urandom_range(1, 2), 1'b0);
        elapsed = 0;
        while (elapsed < hold) begin
            stepv = $urandom_range(hold / 6 + 1, hold / 3 + 1);
            if (stepv > hold - elapsed)
                stepv = hold - elapsed;
            poll_after(stepv, 1'b0);
            elapsed += stepv;
        end
        n = $urandom_range(0, 3);
        for (k = 0; k < n; k++)
            poll_after($urandom_range(0, deb / 2 + 1), !k[0]);
        poll_after($urandom_range(0, deb / 2 + 1), 1'b1);
        poll_after(near(deb), 1'b1);
        poll_after($urandom_range(1, 2), 1'b1);
        repeat ($urandom_range(0, 2)) poll_after($urandom_range(0, deb + 5), 1'b1);
    endtask

    task automatic noise_burst();
        int   k;
        int   n;
        logic pin;
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++) begin
            pin = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 3))
                0: poll_after(0, pin);
                1: poll_after($urandom_range(0, 50), pin);
                2: poll_after($urandom(), pin);
                default: begin
                    poll_clock = $urandom();
                    poll_after(0, pin);
                end
            endcase
        end
    endtask

    task automatic test_register_defaults();
        check_register(REG_DEBOUNCE,  DEBOUNCE_RST);
        check_register(REG_LONG,      LONG_RST);
        check_register(REG_SHORT_MAX, SHORT_MAX_RST);
    endtask

    task automatic test_register_writes();
        set_config(16'h1234, 16'hFFFF, 16'h0000);
        write_register(REG_NONE, $urandom());
        check_register(REG_DEBOUNCE,  16'h1234);
        check_register(REG_LONG,      16'hFFFF);
        check_register(REG_SHORT_MAX, 16'h0000);
    endtask

    task automatic test_directed_polls();
        set_config(16'd10, 16'd100, 16'd50);
        // bounce, then a short press
        send_poll(32'd1000, 1'b1);
        send_poll(32'd1005, 1'b0);
        send_poll(32'd1010, 1'b1);
        send_poll(32'd1012, 1'b0);
        send_poll(32'd1021, 1'b0);
        send_poll(32'd1022, 1'b0);
        send_poll(32'd1060, 1'b0);
        send_poll(32'd1061, 1'b1);
        send_poll(32'd1071, 1'b1);
        // long press at the limit, reported once, release silent
        send_poll(32'd1100, 1'b0);
        send_poll(32'd1110, 1'b0);
        send_poll(32'd1209, 1'b0);
        send_poll(32'd1210, 1'b0);
        send_poll(32'd1300, 1'b0);
        send_poll(32'd1301, 1'b1);
        send_poll(32'd1311, 1'b1);
        // release between short and long limits
        send_poll(32'd1400, 1'b0);
        send_poll(32'd1410, 1'b0);
        send_poll(32'd1470, 1'b1);
        send_poll(32'd1480, 1'b1);
        // all limits zero, across the timestamp wrap
        set_config(16'd0, 16'd0, 16'd0);
        send_poll(32'hFFFF_FFFE, 1'b0);
        send_poll(32'hFFFF_FFFF, 1'b0);
        send_poll(32'd0, 1'b1);
        send_poll(32'd0, 1'b1);
        send_poll(32'd1, 1'b0);
        send_poll(32'd1, 1'b0);
        send_poll(32'd2, 1'b0);
    endtask

    task automatic test_random_polls();
        int          mode;
        int          setting;
        int unsigned phase_end;
        for (mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin send_idle_pct = 8;  recv_idle_pct = 87; end
                1: begin send_idle_pct = 87; recv_idle_pct = 8;  end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (setting = 0; setting < 5; setting++) begin
                case (setting)
                    0: set_config(DEBOUNCE_RST, LONG_RST, SHORT_MAX_RST);
                    1: set_config(16'($urandom_range(0, 8)), 16'($urandom_range(0, 60)),
                                  16'($urandom_range(0, 60)));
                    2: set_config(16'd0, 16'd0, 16'd0);
                    3: set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
                    default: set_config(16'($urandom_range(0, 65535)),
                                        16'($urandom_range(0, 65535)),
                                        16'($urandom_range(0, 65535)));
                endcase
                if ($urandom_range(0, 1))
                    poll_clock = 32'hFFFF_FFFF - $urandom_range(0, 200000);
                else
                    poll_clock = $urandom();
                phase_end = n_polls + ITEMS_PER_PHASE;
                while (n_polls < phase_end) begin
                    if ($urandom_range(0, 4) == 0)
                        noise_burst();
                    else
                        press_sequence();
                end
            end
        end
    endtask

    initial begin
        send_idle_pct = 8;
        recv_idle_pct = 87;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_register_defaults();
        test_register_writes();
        test_directed_polls();
        test_random_polls();
        drain_results();
        repeat (8) @(posedge i_clk);
        $display("%0d polls checked, %0d short and %0d long presses reported",
                 n_polls, short_seen, long_seen);
        $display("%0d register accesses across 18 limit settings and three stall patterns",
                 n_reg_ops);
        if (n_fail == 0)
            $display("button_debounce_press_classifier regression: pass");
        else
            $display("button_debounce_press_classifier regression: fail");
        $finish;
    end

endmodule
